// File: sv/nearest_of_three_server_dispatch_defines.svh
// assertion macros for the nearest-of-three server dispatcher
`ifndef NEAREST_OF_THREE_SERVER_DISPATCH_DEFINES_SVH
`define NEAREST_OF_THREE_SERVER_DISPATCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NOSD_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define NOSD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// File: sv/nosd_pkg.sv
// shared types and constants for the nearest-of-three server dispatcher
`timescale 1ns / 1ps

package nosd_pkg;

    localparam int COORD_BITS   = 10;
    localparam int TOTAL_BITS   = 32;
    localparam int SQ_BITS      = 2 * COORD_BITS + 1;
    localparam int DIST_BITS    = COORD_BITS + 1;
    localparam int SRV_BITS     = 2;
    localparam int NUM_SRV      = 3;
    localparam int NUM_CFG      = 2 * NUM_SRV;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [DIST_BITS-1:0] MAX_DIST = DIST_BITS'(1447);

    // operation codes
    localparam logic OP_SERVE = 1'b0;
    localparam logic OP_HOME  = 1'b1;

    // server codes
    localparam logic [SRV_BITS-1:0] SRV_A = 2'd0;
    localparam logic [SRV_BITS-1:0] SRV_B = 2'd1;
    localparam logic [SRV_BITS-1:0] SRV_C = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_A_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_A_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_B_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_B_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_C_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_C_Y = 3'd5;

    localparam logic [COORD_BITS-1:0] HOME_RST [NUM_CFG] = '{
        COORD_BITS'(39), COORD_BITS'(29), COORD_BITS'(659),
        COORD_BITS'(29), COORD_BITS'(334), COORD_BITS'(619)
    };

    typedef struct packed {
        logic                  operation;
        logic [COORD_BITS-1:0] request_x;
        logic [COORD_BITS-1:0] request_y;
    } t_in_item;

    typedef struct packed {
        logic [SRV_BITS-1:0]   chosen_server;
        logic [DIST_BITS-1:0]  move_distance;
        logic [TOTAL_BITS-1:0] server_total;
    } t_out_item;

endpackage

// File: sv/nearest_of_three_server_dispatch.sv
// top level of the nearest-of-three server dispatcher
`timescale 1ns / 1ps
`include "nearest_of_three_server_dispatch_defines.svh"

// Greedy dispatcher for three servers A, B and C on a 2-D grid. A serve
// transaction brings a point; the block finds each server's distance as
// floor(sqrt(dx*dx + dy*dy)), picks the nearest (A wins only when strictly
// nearer than both others, B when no farther than A and strictly nearer than
// C, C otherwise), moves that server to the point and adds the distance to
// its saturating travel total. A home transaction puts all servers back at
// the configured homes, clears the totals and returns an all-zero result.
// Home registers change the homes only; positions pick them up at the next
// home transaction, while reset puts homes and positions back to the
// defaults. One input transaction is worked at a time: a serve is accepted,
// then for each of the three servers uses the shared squarer (dx*dx, then
// dy*dy plus accumulate) and the shared one-bit-pair square root step, then
// picks and updates; a home goes straight to finish. The finish state waits
// while a previous result still sits unclaimed in the output register.
module nearest_of_three_server_dispatch (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  nosd_pkg::t_in_item                   i_in_data,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output nosd_pkg::t_out_item                  o_out_data,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nosd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [nosd_pkg::COORD_BITS-1:0]      i_cfg_data
);
    import nosd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_FINISH
    } t_state;

    t_state r_state;

    // configuration and server state
    logic [COORD_BITS-1:0] r_home  [NUM_CFG];
    logic [COORD_BITS-1:0] r_pos_x [NUM_SRV];
    logic [COORD_BITS-1:0] r_pos_y [NUM_SRV];
    logic [TOTAL_BITS-1:0] r_total [NUM_SRV];

    // current transaction
    logic                  r_op;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [SRV_BITS-1:0]   r_srv;
    logic [DIST_BITS-1:0]  r_dist [NUM_SRV];

    // square and root datapath
    logic [SQ_BITS-1:0] r_acc;
    logic [SQ_BITS-1:0] r_rem;
    logic [SQ_BITS-1:0] r_root;
    logic [SQ_BITS-1:0] r_bit;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic                    w_in_accept;
    logic                    w_out_free;
    logic [COORD_BITS-1:0]   w_sx;
    logic [COORD_BITS-1:0]   w_sy;
    logic [COORD_BITS-1:0]   w_opa;
    logic [COORD_BITS-1:0]   w_opb;
    logic [COORD_BITS-1:0]   w_diff;
    logic [2*COORD_BITS-1:0] w_sq;
    logic [SQ_BITS:0]        w_trial;
    logic                    w_take;
    logic [SQ_BITS-1:0]      n_rem;
    logic [SQ_BITS-1:0]      n_root;
    logic [SRV_BITS-1:0]     w_sel;
    logic [DIST_BITS-1:0]    w_d;
    logic [TOTAL_BITS-1:0]   w_old_total;
    logic [TOTAL_BITS:0]     w_sum;
    logic [TOTAL_BITS-1:0]   n_total;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // position of the server being measured
    always_comb begin
        case (r_srv)
            SRV_A: begin
                w_sx = r_pos_x[0];
                w_sy = r_pos_y[0];
            end
            SRV_B: begin
                w_sx = r_pos_x[1];
                w_sy = r_pos_y[1];
            end
            default: begin
                w_sx = r_pos_x[2];
                w_sy = r_pos_y[2];
            end
        endcase
    end

    // shared squarer: x leg in SQX, y leg otherwise
    always_comb begin
        if (r_state == S_SQX) begin
            w_opa = w_sx;
            w_opb = r_px;
        end else begin
            w_opa = w_sy;
            w_opb = r_py;
        end
        w_diff = (w_opa > w_opb) ? (w_opa - w_opb) : (w_opb - w_opa);
        w_sq   = w_diff * w_diff;
    end

    // shared root step, one result bit per cycle
    always_comb begin
        w_trial = {1'b0, r_root} + {1'b0, r_bit};
        w_take  = ({1'b0, r_rem} >= w_trial);
        if (w_take) begin
            n_rem  = r_rem - w_trial[SQ_BITS-1:0];
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
    end

    // pick the server and its new total
    always_comb begin
        if (r_dist[0] < r_dist[1]) begin
            w_sel = (r_dist[0] < r_dist[2]) ? SRV_A : SRV_C;
        end else begin
            w_sel = (r_dist[1] < r_dist[2]) ? SRV_B : SRV_C;
        end
        case (w_sel)
            SRV_A: begin
                w_d         = r_dist[0];
                w_old_total = r_total[0];
            end
            SRV_B: begin
                w_d         = r_dist[1];
                w_old_total = r_total[1];
            end
            default: begin
                w_d         = r_dist[2];
                w_old_total = r_total[2];
            end
        endcase
        w_sum   = {1'b0, w_old_total} + {{(TOTAL_BITS + 1 - DIST_BITS){1'b0}}, w_d};
        n_total = w_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : w_sum[TOTAL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_srv       <= SRV_A;
            for (int k = 0; k < NUM_CFG; k++) begin
                r_home[k] <= HOME_RST[k];
            end
            for (int k = 0; k < NUM_SRV; k++) begin
                r_pos_x[k] <= HOME_RST[2*k];
                r_pos_y[k] <= HOME_RST[2*k+1];
                r_total[k] <= '0;
            end
        end else begin
            // home registers, out-of-range index dropped
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_HOME_C_Y)) begin
                r_home[i_cfg_index] <= i_cfg_data;
            end

            // the finish cycle refills the register itself
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_op  <= i_in_data.operation;
                        r_px  <= i_in_data.request_x;
                        r_py  <= i_in_data.request_y;
                        r_srv <= SRV_A;
                        r_state <= (i_in_data.operation == OP_HOME) ? S_FINISH : S_SQX;
                    end
                end
                S_SQX: begin
                    r_acc   <= {1'b0, w_sq};
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_rem   <= r_acc + {1'b0, w_sq};
                    r_root  <= '0;
                    r_bit   <= {1'b1, {(SQ_BITS-1){1'b0}}};
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        for (int k = 0; k < NUM_SRV; k++) begin
                            if (r_srv == SRV_BITS'(k)) begin
                                r_dist[k] <= n_root[DIST_BITS-1:0];
                            end
                        end
                        if (r_srv == SRV_C) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_srv   <= r_srv + 1'b1;
                            r_state <= S_SQX;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_op == OP_HOME) begin
                            r_out_data <= '0;
                            r_pos_x[0] <= r_home[CFG_HOME_A_X];
                            r_pos_y[0] <= r_home[CFG_HOME_A_Y];
                            r_pos_x[1] <= r_home[CFG_HOME_B_X];
                            r_pos_y[1] <= r_home[CFG_HOME_B_Y];
                            r_pos_x[2] <= r_home[CFG_HOME_C_X];
                            r_pos_y[2] <= r_home[CFG_HOME_C_Y];
                            for (int k = 0; k < NUM_SRV; k++) begin
                                r_total[k] <= '0;
                            end
                        end else begin
                            r_out_data.chosen_server <= w_sel;
                            r_out_data.move_distance <= w_d;
                            r_out_data.server_total  <= n_total;
                            for (int k = 0; k < NUM_SRV; k++) begin
                                if (w_sel == SRV_BITS'(k)) begin
                                    r_pos_x[k] <= r_px;
                                    r_pos_y[k] <= r_py;
                                    r_total[k] <= n_total;
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a taken request always starts work
    `NOSD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_in_accept, r_state != S_IDLE)
    // the root step always has exactly one bit pair in flight
    `NOSD_ASSERT_NOW(a_root_bit, i_clk, i_rst_n, r_state == S_ROOT, $onehot(r_bit))
    // a shown distance never exceeds the grid diagonal
    `NOSD_ASSERT_NOW(a_dist_range, i_clk, i_rst_n, r_out_valid, r_out_data.move_distance <= MAX_DIST)
    // a shown result names a real server
    `NOSD_ASSERT_NOW(a_srv_code, i_clk, i_rst_n, r_out_valid, r_out_data.chosen_server != 2'd3)

endmodule
